// ===== hw/rtl/lsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lsl_pkg
// Types and constants shared by the lux calculation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lsl_pkg;

   localparam int CH_W      = 25;  // scaled channel count width
   localparam int BASE_W    = 15;  // integration scale width before gain shift
   localparam int SCALE_W   = 19;  // scale after optional shift by 4
   localparam int FRAC_W    = 10;  // channel scale fraction bits
   localparam int THRESH_W  = 36;  // width of ratio threshold products
   localparam int SLOPE_W   = 10;
   localparam int PROD_W    = 35;  // channel count times slope
   localparam int LUX_W     = 21;
   localparam int LUX_SHIFT = 14;
   localparam int SEG_COUNT = 7;
   localparam int SEG_W     = 3;

   localparam logic [BASE_W-1:0] SCALE_T13  = 15'h7517;
   localparam logic [BASE_W-1:0] SCALE_T101 = 15'h0FE7;
   localparam logic [BASE_W-1:0] SCALE_T402 = 15'h0400;

   // ratio <= knee holds exactly when (ir << 10) < (2*knee + 1) * full
   localparam logic [10:0] SEG_LIMIT [SEG_COUNT] = '{
      11'd129, 11'd257, 11'd385, 11'd513, 11'd625, 11'd821, 11'd1333
   };

   // last entry serves ratios above the final knee
   localparam logic [SLOPE_W-1:0] SEG_B [SEG_COUNT+1] = '{
      10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
   };
   localparam logic [SLOPE_W-1:0] SEG_M [SEG_COUNT+1] = '{
      10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
   };

   typedef enum logic [1:0] {
      INT_13MS  = 2'd0,
      INT_101MS = 2'd1,
      INT_402MS = 2'd2
   } integration_type;

   typedef enum logic {
      CSR_INTEGRATION = 1'b0,
      CSR_HIGH_GAIN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] full_count;
      logic [15:0] ir_count;
   } req_type;

   typedef struct packed {
      logic [LUX_W-1:0] lux;
      logic             clamped;
   } rsp_type;

   typedef struct packed {
      logic [1:0] integration_select;
      logic       high_gain;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] ch0;
      logic [CH_W-1:0] ch1;
   } ch_type;

   typedef struct packed {
      logic [CH_W-1:0]    ch0;
      logic [CH_W-1:0]    ch1;
      logic [SLOPE_W-1:0] b;
      logic [SLOPE_W-1:0] m;
   } seg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsl_scale.sv =====
// ----------------------------------------------------------------------------
// lsl_scale
// Stage 1: scale both raw counts by the integration and gain factor.
// ----------------------------------------------------------------------------
`default_nettype none

module lsl_scale (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  lsl_pkg::req_type     in_item,
   input  lsl_pkg::cfg_type     cfg,
   output logic                 out_valid,
   output lsl_pkg::ch_type      out_ch
);
   import lsl_pkg::*;

   logic [BASE_W-1:0]     base;
   logic [SCALE_W-1:0]    scale;
   logic [SCALE_W+15:0]   full_prod;
   logic [SCALE_W+15:0]   ir_prod;
   ch_type                ch_in;
   ch_type                ch_ff;
   logic                  valid_ff;

   always_comb begin
      case (cfg.integration_select)
         INT_13MS:  base = SCALE_T13;
         INT_101MS: base = SCALE_T101;
         default:   base = SCALE_T402;
      endcase
      // 1x gain: counts are worth 16 times more
      scale     = cfg.high_gain ? {4'b0000, base} : {base, 4'b0000};
      full_prod = (SCALE_W+16)'(in_item.full_count) * (SCALE_W+16)'(scale);
      ir_prod   = (SCALE_W+16)'(in_item.ir_count) * (SCALE_W+16)'(scale);
      ch_in.ch0 = full_prod[FRAC_W +: CH_W];
      ch_in.ch1 = ir_prod[FRAC_W +: CH_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ch_ff <= ch_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ch    = ch_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lsl_segment.sv =====
// ----------------------------------------------------------------------------
// lsl_segment
// Stages 2 and 3: compare the ir/full ratio against the segment knees
// without division and pick the slope pair.
// ----------------------------------------------------------------------------
`default_nettype none

module lsl_segment (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  lsl_pkg::ch_type      in_ch,
   output logic                 out_valid,
   output lsl_pkg::seg_type     out_seg
);
   import lsl_pkg::*;

   logic [THRESH_W-1:0] thresh_in [SEG_COUNT];
   logic [THRESH_W-1:0] thresh_ff [SEG_COUNT];
   ch_type              ch_ff;
   logic                zero_ff;
   logic                valid2_ff;
   logic [THRESH_W-1:0] ir_scaled;
   logic [SEG_COUNT-1:0] below;
   logic [SEG_W-1:0]    seg_idx;
   seg_type             seg_in;
   seg_type             seg_ff;
   logic                valid3_ff;

   // stage 2: threshold products for every knee
   always_comb begin
      for (int i = 0; i < SEG_COUNT; i++) begin
         thresh_in[i] = THRESH_W'(in_ch.ch0) * THRESH_W'(SEG_LIMIT[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         thresh_ff <= thresh_in;
         ch_ff     <= in_ch;
         zero_ff   <= (in_ch.ch0 == '0);
         seg_ff    <= seg_in;
      end
   end

   // stage 3: first knee the ratio does not exceed
   always_comb begin
      ir_scaled = {1'b0, ch_ff.ch1, {FRAC_W{1'b0}}};
      for (int i = 0; i < SEG_COUNT; i++) begin
         below[i] = (ir_scaled < thresh_ff[i]);
      end
      seg_idx = SEG_W'(SEG_COUNT);
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (below[i]) begin
            seg_idx = SEG_W'(i);
         end
      end
      // zero full count: ratio taken as zero
      if (zero_ff) begin
         seg_idx = '0;
      end
      seg_in.ch0 = ch_ff.ch0;
      seg_in.ch1 = ch_ff.ch1;
      seg_in.b   = SEG_B[seg_idx];
      seg_in.m   = SEG_M[seg_idx];
   end

   assign out_valid = valid3_ff;
   assign out_seg   = seg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lsl_lux.sv =====
// ----------------------------------------------------------------------------
// lsl_lux
// Stages 4 and 5: slope products, difference, clamp, round and shift.
// Stage 5 is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsl_lux (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  lsl_pkg::seg_type     in_seg,
   output logic                 out_valid,
   output lsl_pkg::rsp_type     out_item
);
   import lsl_pkg::*;

   logic [PROD_W-1:0]   pos_in;
   logic [PROD_W-1:0]   neg_in;
   logic [PROD_W-1:0]   pos_ff;
   logic [PROD_W-1:0]   neg_ff;
   logic                valid4_ff;
   logic [PROD_W-1:0]   diff;
   logic [PROD_W:0]     rounded;
   logic [PROD_W-LUX_SHIFT:0] shifted;
   rsp_type             rsp_in;
   rsp_type             rsp_ff;
   logic                valid5_ff;

   assign pos_in = PROD_W'(in_seg.ch0) * PROD_W'(in_seg.b);
   assign neg_in = PROD_W'(in_seg.ch1) * PROD_W'(in_seg.m);

   always_comb begin
      diff    = pos_ff - neg_ff;
      rounded = {1'b0, diff} + (PROD_W+1)'(1 << (LUX_SHIFT - 1));
      shifted = rounded[PROD_W:LUX_SHIFT];
      if (neg_ff > pos_ff) begin
         rsp_in.lux     = '0;
         rsp_in.clamped = 1'b1;
      end else begin
         // saturate anything past the lux range
         if (shifted[PROD_W-LUX_SHIFT:LUX_W] != '0) begin
            rsp_in.lux = '1;
         end else begin
            rsp_in.lux = shifted[LUX_W-1:0];
         end
         rsp_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (advance) begin
         valid4_ff <= in_valid;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid5_ff;
   assign out_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/light_sensor_lux_calc.sv =====
// Throughput: one item per cycle; the five-stage pipeline advances as a whole
// whenever the result register is empty or its item is being taken.
// Reset (synchronous, active high) empties every stage and sets the
// configuration to 13 ms integration and 16x gain.
// ----------------------------------------------------------------------------
// light_sensor_lux_calc
// Lux from full-spectrum and infrared counts, T package slope table.
// ----------------------------------------------------------------------------
`default_nettype none

module light_sensor_lux_calc (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  lsl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output lsl_pkg::rsp_type  rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [1:0]   csr_wdata
);
   import lsl_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     advance;
   logic     s1_valid;
   ch_type   s1_ch;
   logic     s3_valid;
   seg_type  s3_seg;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INTEGRATION: cfg_in.integration_select = csr_wdata;
            CSR_HIGH_GAIN:   cfg_in.high_gain = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integration_select <= INT_13MS;
         cfg_ff.high_gain          <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold every stage while the result waits
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   lsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (req_data),
      .cfg       (cfg_ff),
      .out_valid (s1_valid),
      .out_ch    (s1_ch)
   );

   lsl_segment u_segment (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid),
      .in_ch     (s1_ch),
      .out_valid (s3_valid),
      .out_seg   (s3_seg)
   );

   lsl_lux u_lux (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid),
      .in_seg    (s3_seg),
      .out_valid (rsp_valid),
      .out_item  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lsl_checker.sv =====
// ----------------------------------------------------------------------------
// lsl_checker
// Port-level checks on the lux pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsl_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input lsl_pkg::rsp_type  rsp_data
);
   import lsl_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // clamp forces zero lux
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamped |-> rsp_data.lux == '0)
      else $error("clamped item with non-zero lux");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind light_sensor_lux_calc lsl_checker u_lsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
